>>> rtl/mpjq_pkg.sv
// Shared request codes and cell command type for the job queue.
package mpjq_pkg;

    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_cmd;

endpackage

>>> rtl/mpjq_cell.sv
// One slot of the sorted job chain: holds a job and shifts with its neighbors.
module mpjq_cell #(
    parameter int KEY_BITS = 16,
    parameter int TAG_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mpjq_pkg::t_cell_cmd  i_cmd,
    input  logic [KEY_BITS-1:0]  i_new_key,
    input  logic [TAG_BITS-1:0]  i_new_tag,
    input  logic                 i_left_keep,
    input  logic                 i_left_valid,
    input  logic [KEY_BITS-1:0]  i_left_key,
    input  logic [TAG_BITS-1:0]  i_left_tag,
    input  logic                 i_right_valid,
    input  logic [KEY_BITS-1:0]  i_right_key,
    input  logic [TAG_BITS-1:0]  i_right_tag,
    output logic                 o_keep,
    output logic                 o_valid,
    output logic [KEY_BITS-1:0]  o_key,
    output logic [TAG_BITS-1:0]  o_tag
);
    import mpjq_pkg::*;

    logic                r_valid;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic                n_valid;
    logic [KEY_BITS-1:0] n_key;
    logic [TAG_BITS-1:0] n_tag;
    logic                w_keep;

    // A held job stays put when the new job does not beat it; equal keys keep
    // the older job ahead.
    assign w_keep = r_valid && (r_key <= i_new_key);

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_tag   = r_tag;
        if (i_cmd.enq && !w_keep) begin
            if (i_left_keep) begin
                n_valid = 1'b1;
                n_key   = i_new_key;
                n_tag   = i_new_tag;
            end else begin
                n_valid = i_left_valid;
                n_key   = i_left_key;
                n_tag   = i_left_tag;
            end
        end else if (i_cmd.deq) begin
            n_valid = i_right_valid;
            n_key   = i_right_key;
            n_tag   = i_right_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_keep  = w_keep;
    assign o_valid = r_valid;
    assign o_key   = r_key;
    assign o_tag   = r_tag;

endmodule

>>> rtl/min_priority_job_queue.sv
// Top level of the sorted min-priority job queue built as a chain of cells.
//
//   channel  direction  handshake          payload
//   request  in         i_valid / o_ready  i_req_type, i_job_tag, i_pages
//   result   out        o_valid / i_ready  o_job_valid, o_out_tag, o_out_pages,
//                                          o_was_empty, o_overflowed, o_occupancy
//
// Every request beat is handled at once: all cells shift or hold in parallel,
// and the result is registered and shown the cycle after acceptance.
// A new request is taken every cycle while the result register drains each cycle;
// o_ready is low only while an untaken result sits in the output register.
// Reset (synchronous, active low) empties the chain.
module min_priority_job_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int KEY_BITS    = 16,
    parameter int TAG_BITS    = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_req_type,
    input  logic [TAG_BITS-1:0]                  i_job_tag,
    input  logic [KEY_BITS-1:0]                  i_pages,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic                                 o_job_valid,
    output logic [TAG_BITS-1:0]                  o_out_tag,
    output logic [KEY_BITS-1:0]                  o_out_pages,
    output logic                                 o_was_empty,
    output logic                                 o_overflowed,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_occupancy
);
    import mpjq_pkg::*;

    localparam int OCC_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [QUEUE_DEPTH-1:0] w_valid;
    logic [QUEUE_DEPTH-1:0] w_keep;
    logic [QUEUE_DEPTH-1:0] w_valid_inc;
    logic [KEY_BITS-1:0]    w_key [QUEUE_DEPTH];
    logic [TAG_BITS-1:0]    w_tag [QUEUE_DEPTH];
    t_cell_cmd              w_cmd;
    logic                   w_accept;
    logic                   w_full;
    logic                   w_empty;

    logic                   r_out_valid;
    logic                   r_job_valid;
    logic [TAG_BITS-1:0]    r_out_tag;
    logic [KEY_BITS-1:0]    r_out_pages;
    logic                   r_was_empty;
    logic                   r_overflowed;
    logic [OCC_BITS-1:0]    r_occupancy;
    logic [OCC_BITS-1:0]    r_count;
    logic [OCC_BITS-1:0]    n_count;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_full   = w_valid[QUEUE_DEPTH-1];
    assign w_empty  = !w_valid[0];

    assign w_cmd.enq = w_accept && (i_req_type == REQ_ENQ) && !w_full;
    assign w_cmd.deq = w_accept && (i_req_type == REQ_DEQ) && !w_empty;

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        logic                w_lkeep;
        logic                w_lvalid;
        logic [KEY_BITS-1:0] w_lkey;
        logic [TAG_BITS-1:0] w_ltag;
        logic                w_rvalid;
        logic [KEY_BITS-1:0] w_rkey;
        logic [TAG_BITS-1:0] w_rtag;

        // The head cell sees a virtual kept neighbor, so it takes the new job
        // whenever its own job must move.
        if (g == 0) begin : g_head
            assign w_lkeep  = 1'b1;
            assign w_lvalid = 1'b0;
            assign w_lkey   = '0;
            assign w_ltag   = '0;
        end else begin : g_mid
            assign w_lkeep  = w_keep[g-1];
            assign w_lvalid = w_valid[g-1];
            assign w_lkey   = w_key[g-1];
            assign w_ltag   = w_tag[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign w_rvalid = 1'b0;
            assign w_rkey   = '0;
            assign w_rtag   = '0;
        end else begin : g_body
            assign w_rvalid = w_valid[g+1];
            assign w_rkey   = w_key[g+1];
            assign w_rtag   = w_tag[g+1];
        end

        mpjq_cell #(
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_new_key     (i_pages),
            .i_new_tag     (i_job_tag),
            .i_left_keep   (w_lkeep),
            .i_left_valid  (w_lvalid),
            .i_left_key    (w_lkey),
            .i_left_tag    (w_ltag),
            .i_right_valid (w_rvalid),
            .i_right_key   (w_rkey),
            .i_right_tag   (w_rtag),
            .o_keep        (w_keep[g]),
            .o_valid       (w_valid[g]),
            .o_key         (w_key[g]),
            .o_tag         (w_tag[g])
        );
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.enq) begin
            n_count = r_count + {{(OCC_BITS-1){1'b0}}, 1'b1};
        end else if (w_cmd.deq) begin
            n_count = r_count - {{(OCC_BITS-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job_valid  <= w_cmd.deq;
            r_out_tag    <= w_cmd.deq ? w_tag[0] : '0;
            r_out_pages  <= w_cmd.deq ? w_key[0] : '0;
            r_was_empty  <= (i_req_type == REQ_DEQ) && w_empty;
            r_overflowed <= (i_req_type == REQ_ENQ) && w_full;
            r_occupancy  <= n_count;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_job_valid  = r_job_valid;
    assign o_out_tag    = r_out_tag;
    assign o_out_pages  = r_out_pages;
    assign o_was_empty  = r_was_empty;
    assign o_overflowed = r_overflowed;
    assign o_occupancy  = r_occupancy;

    assign w_valid_inc = w_valid + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1};

    // The count register must agree with the number of occupied cells.
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_count))
        else $error("occupancy count disagrees with occupied cells");

    // Occupied cells always form a contiguous run from the head.
    a_valid_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid & w_valid_inc) == '0)
        else $error("occupied cells are not packed at the head");

    // A returned job never comes with an empty or overflow flag.
    a_flags_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_job_valid) |-> (!o_was_empty && !o_overflowed))
        else $error("job returned together with an error flag");

    // A result beat that is not taken holds its occupancy.
    a_occ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> $stable(o_occupancy))
        else $error("stalled result changed occupancy");

endmodule

>>> tb/min_priority_job_queue_tb.sv
// Self-checking testbench for the sorted min-priority job queue with random handshake gaps.
`timescale 1ns / 1ps

module min_priority_job_queue_tb;

    import mpjq_pkg::*;

    localparam int QUEUE_DEPTH   = 16;
    localparam int KEY_BITS      = 16;
    localparam int TAG_BITS      = 8;
    localparam int OCC_BITS      = $clog2(QUEUE_DEPTH + 1);
    localparam int RANDOM_ITEMS  = 1550;
    localparam int DIRECTED_ROWS = 22;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 10;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] pages;
    } t_held_job;

    typedef struct packed {
        logic                job_valid;
        logic [TAG_BITS-1:0] out_tag;
        logic [KEY_BITS-1:0] out_pages;
        logic                was_empty;
        logic                overflowed;
        logic [OCC_BITS-1:0] occupancy;
    } t_queue_result;

    typedef struct packed {
        logic                req;
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] pages;
        logic                typed;
        t_queue_result       want;
    } t_stim_row;

    logic                i_clk        = 1'b0;
    logic                i_rst_n      = 1'b0;
    logic                i_valid      = 1'b0;
    logic                i_req_type   = REQ_ENQ;
    logic [TAG_BITS-1:0] i_job_tag    = '0;
    logic [KEY_BITS-1:0] i_pages      = '0;
    logic                i_ready      = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic                o_job_valid;
    logic [TAG_BITS-1:0] o_out_tag;
    logic [KEY_BITS-1:0] o_out_pages;
    logic                o_was_empty;
    logic                o_overflowed;
    logic [OCC_BITS-1:0] o_occupancy;

    t_held_job     held_jobs[$];
    t_queue_result pending_results[$];
    int            mismatch_count = 0;
    int            idle_cycles    = 0;
    int            ready_hold     = 0;
    bit            streaming      = 1'b0;

    // Typed expectations cover the empty dequeue, the fill to the brim, the dropped
    // enqueue and the first dequeue; ties on zero, the middle and the maximum key
    // are left to the predictor.
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{REQ_DEQ, 8'h00, 16'h0000, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b1, 1'b0, 5'd0}},
        '{REQ_ENQ, 8'hFF, 16'hFFFF, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 5'd1}},
        '{REQ_ENQ, 8'h00, 16'h0000, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 5'd2}},
        '{REQ_ENQ, 8'hA5, 16'hAAAA, 1'b0, '0},
        '{REQ_ENQ, 8'h5A, 16'h5555, 1'b0, '0},
        '{REQ_ENQ, 8'h3C, 16'h5555, 1'b0, '0},
        '{REQ_ENQ, 8'h01, 16'h0000, 1'b0, '0},
        '{REQ_ENQ, 8'h80, 16'h8000, 1'b0, '0},
        '{REQ_ENQ, 8'h7F, 16'h7FFF, 1'b0, '0},
        '{REQ_ENQ, 8'h02, 16'h0001, 1'b0, '0},
        '{REQ_ENQ, 8'h03, 16'hFFFF, 1'b0, '0},
        '{REQ_ENQ, 8'h04, 16'h1234, 1'b0, '0},
        '{REQ_ENQ, 8'h05, 16'h1234, 1'b0, '0},
        '{REQ_ENQ, 8'h06, 16'h0100, 1'b0, '0},
        '{REQ_ENQ, 8'h07, 16'h00FF, 1'b0, '0},
        '{REQ_ENQ, 8'h08, 16'hFFFE, 1'b0, '0},
        '{REQ_ENQ, 8'h09, 16'h5555, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 1'b0, 5'd16}},
        '{REQ_ENQ, 8'hC3, 16'h0002, 1'b1, '{1'b0, 8'h00, 16'h0000, 1'b0, 1'b1, 5'd16}},
        '{REQ_DEQ, 8'hFF, 16'hFFFF, 1'b1, '{1'b1, 8'h00, 16'h0000, 1'b0, 1'b0, 5'd15}},
        '{REQ_DEQ, 8'h00, 16'h0000, 1'b0, '0},
        '{REQ_DEQ, 8'hAA, 16'hAAAA, 1'b0, '0},
        '{REQ_DEQ, 8'h55, 16'h5555, 1'b0, '0}
    };

    min_priority_job_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .KEY_BITS    (KEY_BITS),
        .TAG_BITS    (TAG_BITS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_req_type   (i_req_type),
        .i_job_tag    (i_job_tag),
        .i_pages      (i_pages),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_job_valid  (o_job_valid),
        .o_out_tag    (o_out_tag),
        .o_out_pages  (o_out_pages),
        .o_was_empty  (o_was_empty),
        .o_overflowed (o_overflowed),
        .o_occupancy  (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Applies one request to the shadow queue and returns the result it must produce.
    function automatic t_queue_result predict_request(logic req, logic [TAG_BITS-1:0] tag,
                                                      logic [KEY_BITS-1:0] pages);
        t_queue_result res;
        t_held_job     job;
        int            pos;
        res = '0;
        if (req == REQ_ENQ) begin
            if (held_jobs.size() >= QUEUE_DEPTH) begin
                res.overflowed = 1'b1;
            end else begin
                // The new job goes behind every held job with an equal or smaller key.
                pos = 0;
                while (pos < held_jobs.size() && held_jobs[pos].pages <= pages) pos++;
                job.tag   = tag;
                job.pages = pages;
                held_jobs.insert(pos, job);
            end
        end else if (held_jobs.size() == 0) begin
            res.was_empty = 1'b1;
        end else begin
            job           = held_jobs.pop_front();
            res.job_valid = 1'b1;
            res.out_tag   = job.tag;
            res.out_pages = job.pages;
        end
        res.occupancy = OCC_BITS'(held_jobs.size());
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (streaming || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatch_count++;
    endtask

    // Called right after an edge; leaves i_valid high after the accepting edge so that
    // a following beat with no gap keeps it high with no idle gap between the beats.
    task automatic send_request(logic req, logic [TAG_BITS-1:0] tag, logic [KEY_BITS-1:0] pages,
                                logic typed, t_queue_result want);
        int            gap;
        t_queue_result predicted;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_job_tag  <= tag;
        i_pages    <= pages;
        do @(posedge i_clk); while (!o_ready);
        predicted = predict_request(req, tag, pages);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side: random back-pressure with long open stretches.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < 60) begin
            i_ready    <= 1'b1;
            ready_hold <= $urandom_range(0, 30);
        end else begin
            i_ready    <= 1'b0;
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
        end
    end

    always @(posedge i_clk) begin
        t_queue_result got;
        t_queue_result want;
        if (i_rst_n && o_valid && i_ready) begin
            got = '{o_job_valid, o_out_tag, o_out_pages, o_was_empty, o_overflowed,
                    o_occupancy};
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing expected: %h", got));
            end else begin
                want = pending_results.pop_front();
                if (got.job_valid !== want.job_valid)
                    report_mismatch($sformatf("job_valid %b, expected %b",
                                              got.job_valid, want.job_valid));
                if (got.out_tag !== want.out_tag)
                    report_mismatch($sformatf("out_tag %h, expected %h",
                                              got.out_tag, want.out_tag));
                if (got.out_pages !== want.out_pages)
                    report_mismatch($sformatf("out_pages %h, expected %h",
                                              got.out_pages, want.out_pages));
                if (got.was_empty !== want.was_empty)
                    report_mismatch($sformatf("was_empty %b, expected %b",
                                              got.was_empty, want.was_empty));
                if (got.overflowed !== want.overflowed)
                    report_mismatch($sformatf("overflowed %b, expected %b",
                                              got.overflowed, want.overflowed));
                if (got.occupancy !== want.occupancy)
                    report_mismatch($sformatf("occupancy %0d, expected %0d",
                                              got.occupancy, want.occupancy));
            end
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= STALL_LIMIT) begin
            $display("[%0t] no beat moved for %0d cycles", $time, idle_cycles);
            $display("Some tests failed");
            $finish;
        end else if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                  sent;
        int                  burst_left;
        int                  enq_pct;
        int                  key_mode;
        logic                req;
        logic [KEY_BITS-1:0] pages;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[row])
            send_request(directed_rows[row].req, directed_rows[row].tag,
                         directed_rows[row].pages, directed_rows[row].typed,
                         directed_rows[row].want);

        // Bursts lean toward filling or draining so that the full and empty
        // boundaries are reached again and again; small keys give many ties.
        sent       = 0;
        burst_left = 0;
        enq_pct    = 50;
        while (sent < RANDOM_ITEMS) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 60);
                case ($urandom_range(0, 3))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    2: enq_pct = 85;
                    default: enq_pct = 100;
                endcase
                streaming = ($urandom_range(0, 3) == 0);
            end
            req      = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
            key_mode = $urandom_range(0, 9);
            if (key_mode < 5)
                pages = KEY_BITS'($urandom_range(0, 7));
            else if (key_mode < 8)
                pages = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
            else if (key_mode == 8)
                pages = $urandom_range(0, 1) ? '1 : '0;
            else
                pages = KEY_BITS'($urandom_range((1 << KEY_BITS) - 8, (1 << KEY_BITS) - 1));
            send_request(req, TAG_BITS'($urandom_range(0, (1 << TAG_BITS) - 1)), pages,
                         1'b0, '0);
            burst_left--;
            sent++;
        end
        i_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/mpjq_pkg.sv
rtl/mpjq_cell.sv
rtl/min_priority_job_queue.sv
tb/min_priority_job_queue_tb.sv
